/* rtl/core/monochrome_bitblt_raster_op_top_defines.svh */
`ifndef MONOCHROME_BITBLT_RASTER_OP_TOP_DEFINES_SVH
`define MONOCHROME_BITBLT_RASTER_OP_TOP_DEFINES_SVH

// Same-cycle implication, checked on clk_i outside reset
`define BBROP_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("bbrop check failed");

// Next-cycle implication, checked on clk_i outside reset
`define BBROP_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("bbrop check failed");

`endif

/* rtl/core/bbrop_pkg.sv */
package bbrop_pkg;

  // Default store geometry
  localparam int DEF_MAX_WIDTH  = 256;
  localparam int DEF_MAX_HEIGHT = 128;

  // Internal signed coordinate width (covers the 10-bit fields and sizes up to 1024)
  localparam int CIN_W  = 10;
  localparam int CW     = 12;
  // Row base address width (128 rows of 1024 pixels at most)
  localparam int BASE_W = 17;
  // Command queue depth
  localparam int QDEPTH = 2;

  // Bus functions
  localparam logic [1:0] FN_WR_SRC = 2'd0;
  localparam logic [1:0] FN_WR_FRM = 2'd1;
  localparam logic [1:0] FN_RD_FRM = 2'd2;
  localparam logic [1:0] FN_BLIT   = 2'd3;

  // Result status codes
  localparam logic [1:0] STAT_WRITE = 2'd0;
  localparam logic [1:0] STAT_READ  = 2'd1;
  localparam logic [1:0] STAT_DRAWN = 2'd2;
  localparam logic [1:0] STAT_CLIP  = 2'd3;

  // Source modes
  localparam logic [1:0] MODE_SRC     = 2'd0;
  localparam logic [1:0] MODE_COPY    = 2'd1;
  localparam logic [1:0] MODE_FWD     = 2'd2;
  // Unlisted mode, behaves as the forward frame mode
  localparam logic [1:0] MODE_FWD_ALT = 2'd3;

  // Register indexes
  localparam logic [1:0] REG_SRC_W = 2'd0;
  localparam logic [1:0] REG_SRC_H = 2'd1;
  localparam logic [1:0] REG_FRM_W = 2'd2;
  localparam logic [1:0] REG_FRM_H = 2'd3;

  localparam logic [8:0] RST_SRC_W = 9'd256;
  localparam logic [7:0] RST_SRC_H = 8'd128;
  localparam logic [8:0] RST_FRM_W = 9'd178;
  localparam logic [7:0] RST_FRM_H = 8'd128;

  typedef struct packed {
    logic [8:0] source_width;
    logic [7:0] source_height;
    logic [8:0] frame_width;
    logic [7:0] frame_height;
  } cfg_t;

  // Decoded, clipped command handed from front to back
  typedef struct packed {
    logic [1:0]        func;
    logic [11:0]       addr;
    logic [7:0]        data;
    logic [31:0]       rop;
    logic [1:0]        mode;
    logic              clipped;
    logic [CW-1:0]     sx;
    logic [CW-1:0]     dx;
    logic [CW-1:0]     w;
    logic [CW-1:0]     h;
    logic [CW-1:0]     sstride;
    logic [CW-1:0]     fstride;
    logic [BASE_W-1:0] sbase;
    logic [BASE_W-1:0] dbase;
  } cmd_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_COPY,
    ST_PSRC,
    ST_PDST,
    ST_PWR
  } back_state_e;

  // Register value clamped to [1, hi]
  function automatic logic [CW-1:0] clamp_dim(input logic [8:0] v, input logic [CW-1:0] hi);
    logic [CW-1:0] x;
    begin
      x = CW'(v);
      if (x == '0) x = CW'(1);
      else if (x > hi) x = hi;
      return x;
    end
  endfunction

endpackage

/* rtl/core/bbrop_ram.sv */
module bbrop_ram import bbrop_pkg::*; #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/core/bbrop_fifo.sv */
module bbrop_fifo import bbrop_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t push_data_i,
  input  logic pop_i,
  output cmd_t head_o,
  output logic empty_o,
  output logic full_o
);

  localparam int PW = $clog2(QDEPTH);

  cmd_t              mem_q [QDEPTH];
  logic [PW-1:0]     wptr_q, rptr_q;
  logic [PW:0]       count_q;

  // Entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wptr_q] <= push_data_i;
  end

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      if (push_i) wptr_q <= wptr_q + 1'b1;
      if (pop_i)  rptr_q <= rptr_q + 1'b1;
      count_q <= count_q + (PW+1)'(push_i) - (PW+1)'(pop_i);
    end
  end

  assign head_o  = mem_q[rptr_q];
  assign empty_o = (count_q == '0);
  assign full_o  = (count_q == (PW+1)'(QDEPTH));

endmodule

/* rtl/core/bbrop_front.sv */
module bbrop_front import bbrop_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  output logic                    busy_o,
  input  logic                    clearing_i,
  input  cfg_t                    cfg_i,
  input  logic [1:0]              func_i,
  input  logic [11:0]             byte_address_i,
  input  logic [7:0]              write_data_i,
  input  logic signed [CIN_W-1:0] src_x_i,
  input  logic signed [CIN_W-1:0] src_y_i,
  input  logic signed [CIN_W-1:0] dst_x_i,
  input  logic signed [CIN_W-1:0] dst_y_i,
  input  logic signed [CIN_W-1:0] copy_width_i,
  input  logic signed [CIN_W-1:0] copy_height_i,
  input  logic [31:0]             rop_word_i,
  input  logic [1:0]              source_mode_i,
  input  logic                    q_full_i,
  output logic                    q_push_o,
  output cmd_t                    q_data_o
);

  localparam logic [CW-1:0] MAXW = CW'(MAX_WIDTH);
  localparam logic [CW-1:0] MAXH = CW'(MAX_HEIGHT);

  logic accept;
  logic s1_valid_q;
  logic [1:0]  func_q, mode_q;
  logic [11:0] addr_q;
  logic [7:0]  data_q;
  logic [31:0] rop_q;
  logic signed [CW-1:0] sx_q, sy_q, dx_q, dy_q, w_q, h_q;
  logic signed [CW-1:0] fw_q, fh_q, sw_q, sh_q;

  logic signed [CW-1:0] sx_e, sy_e, dx_e, dy_e, w_e, h_e;
  logic signed [CW-1:0] fw_c, fh_c;
  logic signed [CW-1:0] wa, wb, ha, hb, w2, h2;
  logic [CW-1:0]        sstride, fstride;
  logic [2*CW-1:0]      sprod, dprod;

  assign accept = start_i && !busy_o;
  assign busy_o = clearing_i || s1_valid_q || q_full_i;

  // Sign extension of the rectangle fields
  assign sx_e = {{(CW-CIN_W){src_x_i[CIN_W-1]}}, src_x_i};
  assign sy_e = {{(CW-CIN_W){src_y_i[CIN_W-1]}}, src_y_i};
  assign dx_e = {{(CW-CIN_W){dst_x_i[CIN_W-1]}}, dst_x_i};
  assign dy_e = {{(CW-CIN_W){dst_y_i[CIN_W-1]}}, dst_y_i};
  assign w_e  = {{(CW-CIN_W){copy_width_i[CIN_W-1]}}, copy_width_i};
  assign h_e  = {{(CW-CIN_W){copy_height_i[CIN_W-1]}}, copy_height_i};
  assign fw_c = clamp_dim(cfg_i.frame_width, MAXW);
  assign fh_c = clamp_dim({1'b0, cfg_i.frame_height}, MAXH);

  // Stage 1: capture, trim negative destination start
  always_ff @(posedge clk_i) begin
    if (accept) begin
      func_q <= func_i;
      addr_q <= byte_address_i;
      data_q <= write_data_i;
      rop_q  <= rop_word_i;
      mode_q <= source_mode_i;
      sx_q   <= dx_e[CW-1] ? sx_e - dx_e : sx_e;
      w_q    <= dx_e[CW-1] ? w_e + dx_e : w_e;
      dx_q   <= dx_e[CW-1] ? '0 : dx_e;
      sy_q   <= dy_e[CW-1] ? sy_e - dy_e : sy_e;
      h_q    <= dy_e[CW-1] ? h_e + dy_e : h_e;
      dy_q   <= dy_e[CW-1] ? '0 : dy_e;
      fw_q   <= fw_c;
      fh_q   <= fh_c;
      sw_q   <= (source_mode_i == MODE_SRC) ? clamp_dim(cfg_i.source_width, MAXW) : fw_c;
      sh_q   <= (source_mode_i == MODE_SRC) ?
                clamp_dim({1'b0, cfg_i.source_height}, MAXH) : fh_c;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (accept) begin
      s1_valid_q <= 1'b1;
    end else if (q_push_o) begin
      s1_valid_q <= 1'b0;
    end
  end

  // Stage 2: clip to frame and source, row base addresses
  always_comb begin
    wa = fw_q - dx_q;
    wb = sw_q - sx_q;
    ha = fh_q - dy_q;
    hb = sh_q - sy_q;
    w2 = w_q;
    if (wa < w2) w2 = wa;
    if (wb < w2) w2 = wb;
    h2 = h_q;
    if (ha < h2) h2 = ha;
    if (hb < h2) h2 = hb;
    sstride = (sw_q + CW'(7)) >> 3;
    fstride = (fw_q + CW'(7)) >> 3;
    sprod   = sy_q * sstride;
    dprod   = dy_q * fstride;
  end

  assign q_push_o = s1_valid_q && !q_full_i;

  always_comb begin
    q_data_o.func    = func_q;
    q_data_o.addr    = addr_q;
    q_data_o.data    = data_q;
    q_data_o.rop     = rop_q;
    q_data_o.mode    = mode_q;
    q_data_o.clipped = sx_q[CW-1] || sy_q[CW-1] || (w2 <= 0) || (h2 <= 0);
    q_data_o.sx      = sx_q;
    q_data_o.dx      = dx_q;
    q_data_o.w       = w2;
    q_data_o.h       = h2;
    q_data_o.sstride = sstride;
    q_data_o.fstride = fstride;
    q_data_o.sbase   = sprod[BASE_W-1:0];
    q_data_o.dbase   = dprod[BASE_W-1:0];
  end

endmodule

/* rtl/core/bbrop_back.sv */
module bbrop_back import bbrop_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       q_empty_i,
  input  cmd_t       q_head_i,
  output logic       q_pop_o,
  output logic       clearing_o,
  output logic       done_o,
  output logic [7:0] read_data_o,
  output logic [1:0] status_o
);

  localparam int STORE_N = ((MAX_WIDTH + 7) / 8) * MAX_HEIGHT;
  localparam int AW      = $clog2(STORE_N);
  localparam int CNT_W   = AW + 1;
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(STORE_N - 1);
  localparam logic [CNT_W-1:0] CNT_END  = CNT_W'(STORE_N);

  back_state_e      state_q, state_d;
  cmd_t             cmd_q, cmd_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [CW-1:0]    i_q, i_d, j_q, j_d;
  logic [AW-1:0]    sbase_q, sbase_d, dbase_q, dbase_d;
  logic             sbit_q, sbit_d;
  logic             done_q, res_v;
  logic [7:0]       rdata_q, res_data;
  logic [1:0]       status_q, res_stat;

  logic          f_we, s_we, c_we;
  logic [AW-1:0] f_waddr, f_raddr, c_waddr, saddr, daddr;
  logic [7:0]    f_wdata, f_rdata, s_rdata, c_rdata, sel_byte, new_byte;
  logic [CW-1:0] px, qx;
  logic          head_ok, cmd_ok, dbit, rbit;
  logic [7:0]    rop_a1, rop_x1, rop_a2, rop_x2;

  bbrop_ram #(.WIDTH(8), .DEPTH(STORE_N)) u_src_ram (
    .clk_i, .we_i(s_we), .waddr_i(AW'(q_head_i.addr)), .wdata_i(q_head_i.data),
    .raddr_i(saddr), .rdata_o(s_rdata)
  );
  bbrop_ram #(.WIDTH(8), .DEPTH(STORE_N)) u_frm_ram (
    .clk_i, .we_i(f_we), .waddr_i(f_waddr), .wdata_i(f_wdata),
    .raddr_i(f_raddr), .rdata_o(f_rdata)
  );
  bbrop_ram #(.WIDTH(8), .DEPTH(STORE_N)) u_copy_ram (
    .clk_i, .we_i(c_we), .waddr_i(c_waddr), .wdata_i(f_rdata),
    .raddr_i(saddr), .rdata_o(c_rdata)
  );

  // Pixel addressing
  assign px      = cmd_q.sx + i_q;
  assign qx      = cmd_q.dx + i_q;
  assign saddr   = sbase_q + AW'(px[CW-1:3]);
  assign daddr   = dbase_q + AW'(qx[CW-1:3]);
  assign head_ok = (32'(q_head_i.addr) < 32'(STORE_N));
  assign cmd_ok  = (32'(cmd_q.addr) < 32'(STORE_N));

  // Raster op on one pixel
  assign rop_a1 = cmd_q.rop[31:24];
  assign rop_x1 = cmd_q.rop[23:16];
  assign rop_a2 = cmd_q.rop[15:8];
  assign rop_x2 = cmd_q.rop[7:0];
  assign dbit   = f_rdata[qx[2:0]];
  assign rbit   = (dbit & ((sbit_q & rop_a1[px[2:0]]) ^ rop_x1[px[2:0]])) ^
                  ((sbit_q & rop_a2[px[2:0]]) ^ rop_x2[px[2:0]]);

  always_comb begin
    new_byte = f_rdata;
    new_byte[qx[2:0]] = rbit;
  end

  // Source byte by mode
  always_comb begin
    case (cmd_q.mode)
      MODE_SRC:  sel_byte = s_rdata;
      MODE_COPY: sel_byte = c_rdata;
      default:   sel_byte = f_rdata;
    endcase
  end

  // Sequencer
  always_comb begin
    state_d  = state_q;
    cmd_d    = cmd_q;
    cnt_d    = cnt_q;
    i_d      = i_q;
    j_d      = j_q;
    sbase_d  = sbase_q;
    dbase_d  = dbase_q;
    sbit_d   = sbit_q;
    q_pop_o  = 1'b0;
    res_v    = 1'b0;
    res_data = '0;
    res_stat = STAT_WRITE;
    f_we     = 1'b0;
    f_waddr  = daddr;
    f_wdata  = new_byte;
    f_raddr  = saddr;
    s_we     = 1'b0;
    c_we     = 1'b0;
    c_waddr  = AW'(cnt_q - 1'b1);
    case (state_q)
      ST_CLEAR: begin
        f_we    = 1'b1;
        f_waddr = cnt_q[AW-1:0];
        f_wdata = '0;
        cnt_d   = cnt_q + 1'b1;
        if (cnt_q == CNT_LAST) begin
          cnt_d   = '0;
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (!q_empty_i) begin
          q_pop_o = 1'b1;
          cmd_d   = q_head_i;
          case (q_head_i.func)
            FN_WR_SRC: begin
              s_we  = head_ok;
              res_v = 1'b1;
            end
            FN_WR_FRM: begin
              f_we    = head_ok;
              f_waddr = AW'(q_head_i.addr);
              f_wdata = q_head_i.data;
              res_v   = 1'b1;
            end
            FN_RD_FRM: begin
              f_raddr = AW'(q_head_i.addr);
              state_d = ST_READ;
            end
            default: begin
              if (q_head_i.clipped) begin
                res_v    = 1'b1;
                res_stat = STAT_CLIP;
              end else begin
                i_d     = '0;
                j_d     = '0;
                sbase_d = AW'(q_head_i.sbase);
                dbase_d = AW'(q_head_i.dbase);
                cnt_d   = '0;
                state_d = (q_head_i.mode == MODE_COPY) ? ST_COPY : ST_PSRC;
              end
            end
          endcase
        end
      end
      ST_READ: begin
        res_v    = 1'b1;
        res_stat = STAT_READ;
        res_data = cmd_ok ? f_rdata : '0;
        state_d  = ST_IDLE;
      end
      ST_COPY: begin
        // Snapshot the frame one byte a cycle; each byte is written from the frame memory's registered read data
        if (cnt_q != CNT_END) f_raddr = cnt_q[AW-1:0];
        c_we  = (cnt_q != '0);
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CNT_END) state_d = ST_PSRC;
      end
      ST_PSRC: begin
        state_d = ST_PDST;
      end
      ST_PDST: begin
        f_raddr = daddr;
        sbit_d  = sel_byte[px[2:0]];
        state_d = ST_PWR;
      end
      ST_PWR: begin
        f_we    = 1'b1;
        state_d = ST_PSRC;
        if (i_q == cmd_q.w - 1'b1) begin
          i_d     = '0;
          j_d     = j_q + 1'b1;
          sbase_d = sbase_q + AW'(cmd_q.sstride);
          dbase_d = dbase_q + AW'(cmd_q.fstride);
          if (j_q == cmd_q.h - 1'b1) begin
            res_v    = 1'b1;
            res_stat = STAT_DRAWN;
            state_d  = ST_IDLE;
          end
        end else begin
          i_d = i_q + 1'b1;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      done_q  <= res_v;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q    <= cmd_d;
    i_q      <= i_d;
    j_q      <= j_d;
    sbase_q  <= sbase_d;
    dbase_q  <= dbase_d;
    sbit_q   <= sbit_d;
    rdata_q  <= res_data;
    status_q <= res_stat;
  end

  assign clearing_o  = (state_q == ST_CLEAR);
  assign done_o      = done_q;
  assign read_data_o = rdata_q;
  assign status_o    = status_q;

endmodule

/* rtl/core/monochrome_bitblt_raster_op_top.sv */
// 1-bit-per-pixel blitter with source and frame stores. An item is taken when
// start is high and busy is low; its result appears on read_data_o and
// status_o for exactly one cycle with done_o, and cannot be held off, so the
// receiver must take it then. After reset the frame store is cleared in a pass
// over its ((MAX_WIDTH+7)/8)*MAX_HEIGHT bytes (4096 by default) with busy high;
// configuration writes are taken during it. The front holds a bus item until it
// is pushed to the queue and takes no new item before then; the back end
// finishes a write when it pops it and a read in its ST_READ state. A blit walks
// its clipped rectangle one pixel at a time through the frame memory port in
// three steps (read source, read destination, write); in the overlapping-source
// mode a snapshot pass over the whole frame store through the same port comes
// first. A clipped-away blit is finished by the back end when it is popped.
module monochrome_bitblt_raster_op_top import bbrop_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start,
  output logic                    busy,
  output logic                    done_o,
  input  logic [1:0]              func_i,
  input  logic [11:0]             byte_address_i,
  input  logic [7:0]              write_data_i,
  input  logic signed [CIN_W-1:0] src_x_i,
  input  logic signed [CIN_W-1:0] src_y_i,
  input  logic signed [CIN_W-1:0] dst_x_i,
  input  logic signed [CIN_W-1:0] dst_y_i,
  input  logic signed [CIN_W-1:0] copy_width_i,
  input  logic signed [CIN_W-1:0] copy_height_i,
  input  logic [31:0]             rop_word_i,
  input  logic [1:0]              source_mode_i,
  output logic [7:0]              read_data_o,
  output logic [1:0]              status_o,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [3:0]              paddr,
  input  logic [31:0]             pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);

  cfg_t cfg_q;
  logic q_push, q_pop, q_empty, q_full, clearing;
  cmd_t q_in, q_head;

  // Configuration registers
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.source_width  <= RST_SRC_W;
      cfg_q.source_height <= RST_SRC_H;
      cfg_q.frame_width   <= RST_FRM_W;
      cfg_q.frame_height  <= RST_FRM_H;
    end else if (psel && penable && pwrite) begin
      case (paddr[3:2])
        REG_SRC_W: cfg_q.source_width  <= pwdata[8:0];
        REG_SRC_H: cfg_q.source_height <= pwdata[7:0];
        REG_FRM_W: cfg_q.frame_width   <= pwdata[8:0];
        REG_FRM_H: cfg_q.frame_height  <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_SRC_W: prdata = 32'(cfg_q.source_width);
      REG_SRC_H: prdata = 32'(cfg_q.source_height);
      REG_FRM_W: prdata = 32'(cfg_q.frame_width);
      REG_FRM_H: prdata = 32'(cfg_q.frame_height);
      default:   prdata = '0;
    endcase
  end

  bbrop_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_front (
    .clk_i, .rst_ni,
    .start_i(start), .busy_o(busy), .clearing_i(clearing), .cfg_i(cfg_q),
    .func_i, .byte_address_i, .write_data_i,
    .src_x_i, .src_y_i, .dst_x_i, .dst_y_i, .copy_width_i, .copy_height_i,
    .rop_word_i, .source_mode_i,
    .q_full_i(q_full), .q_push_o(q_push), .q_data_o(q_in)
  );

  bbrop_fifo u_fifo (
    .clk_i, .rst_ni,
    .push_i(q_push), .push_data_i(q_in), .pop_i(q_pop),
    .head_o(q_head), .empty_o(q_empty), .full_o(q_full)
  );

  bbrop_back #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_back (
    .clk_i, .rst_ni,
    .q_empty_i(q_empty), .q_head_i(q_head), .q_pop_o(q_pop),
    .clearing_o(clearing),
    .done_o, .read_data_o, .status_o
  );

endmodule

/* rtl/core/bbrop_checker.sv */
`include "monochrome_bitblt_raster_op_top_defines.svh"

module bbrop_checker import bbrop_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       start,
  input logic       busy,
  input logic       done_o,
  input logic [7:0] read_data_o,
  input logic [1:0] status_o,
  input logic       pready
);

  // A taken transaction raises busy in the next cycle, blocking the next one
  `BBROP_ASSERT_NXT(a_busy_after_take, start && !busy, busy)
  // Only reads carry data
  `BBROP_ASSERT_IMP(a_data_only_on_read, done_o && status_o != STAT_READ, read_data_o == 8'd0)
  // Config port never waits
  `BBROP_ASSERT_IMP(a_pready_high, 1'b1, pready)

endmodule

bind monochrome_bitblt_raster_op_top bbrop_checker u_bbrop_checker (.*);
